FILE: rtl/core/mclb_pkg.sv
package mclb_pkg;

   // widths of the item fields
   localparam int FUNC_W      = 2;
   localparam int LED_INDEX_W = 4;
   localparam int COUNT_IN_W  = 8;
   localparam int PERIOD_W    = 16;
   localparam int NOW_W       = 32;
   localparam int LEVELS_W    = 10;

   // configuration port
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 10;
   localparam logic [CSR_INDEX_W-1:0] CSR_LED_COUNT = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ON_LEVELS = 1'b1;

   // reset and init values
   localparam logic [LED_INDEX_W-1:0] LED_COUNT_RESET = 4'd10;
   localparam logic [LEVELS_W-1:0]    ON_LEVELS_RESET = 10'h3FF;
   localparam logic [PERIOD_W-1:0]    INIT_PERIOD     = 16'd500;

   typedef enum logic [1:0] {
      MODE_IDLE   = 2'd0,
      MODE_HOLD   = 2'd1,
      MODE_TOGGLE = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      FUNC_TICK  = 2'd0,
      FUNC_SET   = 2'd1,
      FUNC_CLEAR = 2'd2
   } func_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_REPLY
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic tick_step;
      logic edit;
      logic reply;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      func_type func;
      logic     last_channel;
      logic     rsp_free;
   } stat_type;

endpackage

FILE: rtl/core/mclb_req_if.sv
interface mclb_req_if import mclb_pkg::*;;
   logic                   valid;
   logic                   ready;
   logic [FUNC_W-1:0]      func;
   logic [LED_INDEX_W-1:0] led_index;
   logic [COUNT_IN_W-1:0]  blink_count;
   logic                   forever_req;
   logic [PERIOD_W-1:0]    period_ms;
   logic [NOW_W-1:0]       now_ms;

   modport source (
      output valid, func, led_index, blink_count, forever_req, period_ms, now_ms,
      input  ready
   );
   modport sink (
      input  valid, func, led_index, blink_count, forever_req, period_ms, now_ms,
      output ready
   );
endinterface

FILE: rtl/core/mclb_rsp_if.sv
interface mclb_rsp_if import mclb_pkg::*;;
   logic                valid;
   logic                ready;
   logic [LEVELS_W-1:0] led_levels;

   modport source (
      output valid, led_levels,
      input  ready
   );
   modport sink (
      input  valid, led_levels,
      output ready
   );
endinterface

FILE: rtl/core/mclb_ctrl.sv
module mclb_ctrl import mclb_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff;
   state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (stat.func != FUNC_TICK || stat.last_channel) begin
               state_in = ST_REPLY;
            end
         end
         ST_REPLY: begin
            if (stat.rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ST_EXEC: begin
            cmd.tick_step = (stat.func == FUNC_TICK);
            cmd.edit      = (stat.func != FUNC_TICK);
         end
         ST_REPLY: begin
            cmd.reply = stat.rsp_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

FILE: rtl/core/mclb_dp.sv
module mclb_dp import mclb_pkg::*; #(
   parameter int NUM_LEDS    = 10,
   parameter int COUNT_WIDTH = 8,
   parameter int TIME_WIDTH  = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cmd_type                cmd,
   output stat_type               stat,
   input  logic [FUNC_W-1:0]      item_func,
   input  logic [LED_INDEX_W-1:0] item_led_index,
   input  logic [COUNT_IN_W-1:0]  item_blink_count,
   input  logic                   item_forever_req,
   input  logic [PERIOD_W-1:0]    item_period_ms,
   input  logic [NOW_W-1:0]       item_now_ms,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output logic [LEVELS_W-1:0]    rsp_led_levels
);

   localparam int IDX_W     = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
   localparam int CNT_EXT_W = (COUNT_WIDTH > COUNT_IN_W) ? COUNT_WIDTH : COUNT_IN_W;
   localparam int CMP_W     = ($clog2(NUM_LEDS + 1) > LED_INDEX_W) ?
                              $clog2(NUM_LEDS + 1) : LED_INDEX_W;
   localparam logic [CMP_W-1:0] NUM_CMP   = CMP_W'(NUM_LEDS);
   localparam logic [CMP_W-1:0] RST_COUNT =
      (CMP_W'(LED_COUNT_RESET) < NUM_CMP) ? CMP_W'(LED_COUNT_RESET) : NUM_CMP;
   localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(NUM_LEDS - 1);

   // per-channel state
   mode_type                mode_ff    [NUM_LEDS];
   logic [COUNT_WIDTH-1:0]  cnt_ff     [NUM_LEDS];
   logic                    forever_ff [NUM_LEDS];
   logic [PERIOD_W-1:0]     period_ff  [NUM_LEDS];
   logic [TIME_WIDTH-1:0]   last_ff    [NUM_LEDS];
   logic [NUM_LEDS-1:0]     pin_ff;
   logic [LEVELS_W-1:0]     on_levels_ff;

   // latched item
   func_type                func_ff;
   logic [LED_INDEX_W-1:0]  idx_ff;
   logic [COUNT_WIDTH-1:0]  blink_ff;
   logic                    forever_req_ff;
   logic [PERIOD_W-1:0]     period_req_ff;
   logic [TIME_WIDTH-1:0]   now_ff;
   logic [IDX_W-1:0]        cursor_ff;

   // result register
   logic                    rsp_valid_ff;
   logic [LEVELS_W-1:0]     rsp_levels_ff;

   logic [CNT_EXT_W-1:0]    blink_ext;
   logic [CMP_W-1:0]        idx_cmp;
   logic [CMP_W-1:0]        csr_count;
   logic [CMP_W-1:0]        csr_sat;
   logic                    idx_in_range;
   logic [IDX_W-1:0]        addr;
   logic [NUM_LEDS-1:0]     on_vec;
   logic [LEVELS_W-1:0]     levels_vec;
   logic                    due;
   logic                    active;
   logic                    ent_wr;
   mode_type                mode_in;
   logic [COUNT_WIDTH-1:0]  cnt_in;
   logic                    forever_in;
   logic [PERIOD_W-1:0]     period_in;
   logic [TIME_WIDTH-1:0]   last_in;
   logic                    pin_in;

   // on levels and result levels, channels past the level field read as off
   for (genvar g = 0; g < NUM_LEDS; g++) begin : g_on
      if (g < LEVELS_W) begin : g_lit
         assign on_vec[g] = on_levels_ff[g];
      end else begin : g_dark
         assign on_vec[g] = 1'b0;
      end
   end
   for (genvar g = 0; g < LEVELS_W; g++) begin : g_lvl
      if (g < NUM_LEDS) begin : g_pin
         assign levels_vec[g] = pin_ff[g];
      end else begin : g_none
         assign levels_vec[g] = 1'b0;
      end
   end

   // addressing
   assign blink_ext    = CNT_EXT_W'(item_blink_count);
   assign idx_cmp      = CMP_W'(idx_ff);
   assign idx_in_range = (idx_cmp < NUM_CMP);
   assign addr         = cmd.tick_step ? cursor_ff : idx_cmp[IDX_W-1:0];
   assign csr_count    = CMP_W'(csr_wdata[LED_INDEX_W-1:0]);
   assign csr_sat      = (csr_count < NUM_CMP) ? csr_count : NUM_CMP;

   // due check with wrapping time
   assign due = ((now_ff - last_ff[addr]) >= TIME_WIDTH'(period_ff[addr]));

   // update of the addressed channel
   always_comb begin
      mode_in    = mode_ff[addr];
      cnt_in     = cnt_ff[addr];
      forever_in = forever_ff[addr];
      period_in  = period_ff[addr];
      last_in    = last_ff[addr];
      pin_in     = pin_ff[addr];
      active     = 1'b1;
      ent_wr     = 1'b0;
      if (cmd.tick_step) begin
         ent_wr = 1'b1;
         case (mode_ff[addr])
            MODE_HOLD: begin
               pin_in = on_vec[addr];
            end
            MODE_TOGGLE: begin
               if (!forever_ff[addr]) begin
                  if (cnt_ff[addr] != '0) begin
                     cnt_in = cnt_ff[addr] - 1'b1;
                  end else begin
                     mode_in = MODE_HOLD;
                     active  = 1'b0;
                  end
               end
               if (active && due) begin
                  pin_in  = ~pin_ff[addr];
                  last_in = now_ff;
               end
            end
            default: begin
               ent_wr = 1'b0;
            end
         endcase
      end else if (cmd.edit && idx_in_range) begin
         case (func_ff)
            FUNC_SET: begin
               ent_wr     = 1'b1;
               cnt_in     = blink_ff;
               forever_in = forever_req_ff;
               period_in  = period_req_ff;
               if (period_req_ff == '0 || (!forever_req_ff && blink_ff == '0)) begin
                  mode_in = MODE_HOLD;
               end else begin
                  mode_in = MODE_TOGGLE;
               end
            end
            FUNC_CLEAR: begin
               ent_wr     = 1'b1;
               cnt_in     = '0;
               forever_in = 1'b1;
               period_in  = '0;
               mode_in    = MODE_HOLD;
            end
            default: begin
               ent_wr = 1'b0;
            end
         endcase
      end
   end

   // channel state, with re-init on a led count write
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_LEDS; i++) begin
            mode_ff[i]    <= (CMP_W'(i) < RST_COUNT) ? MODE_HOLD : MODE_IDLE;
            cnt_ff[i]     <= '0;
            forever_ff[i] <= 1'b1;
            period_ff[i]  <= INIT_PERIOD;
            last_ff[i]    <= '0;
         end
      end else if (csr_wr_en && csr_index == CSR_LED_COUNT) begin
         for (int i = 0; i < NUM_LEDS; i++) begin
            if (CMP_W'(i) < csr_sat) begin
               mode_ff[i]    <= MODE_HOLD;
               cnt_ff[i]     <= '0;
               forever_ff[i] <= 1'b1;
               period_ff[i]  <= INIT_PERIOD;
               last_ff[i]    <= '0;
            end
         end
      end else if (ent_wr) begin
         mode_ff[addr]    <= mode_in;
         cnt_ff[addr]     <= cnt_in;
         forever_ff[addr] <= forever_in;
         period_ff[addr]  <= period_in;
         last_ff[addr]    <= last_in;
      end
   end

   // pin levels and on levels
   always_ff @(posedge clock) begin
      if (reset) begin
         pin_ff       <= '0;
         on_levels_ff <= ON_LEVELS_RESET;
      end else begin
         if (ent_wr) begin
            pin_ff[addr] <= pin_in;
         end
         if (csr_wr_en && csr_index == CSR_ON_LEVELS) begin
            on_levels_ff <= csr_wdata[LEVELS_W-1:0];
         end
      end
   end

   // item capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff        <= func_type'(item_func);
         idx_ff         <= item_led_index;
         blink_ff       <= blink_ext[COUNT_WIDTH-1:0];
         forever_req_ff <= item_forever_req;
         period_req_ff  <= item_period_ms;
         now_ff         <= item_now_ms[TIME_WIDTH-1:0];
      end
   end

   // channel cursor for tick passes
   always_ff @(posedge clock) begin
      if (reset || cmd.capture) begin
         cursor_ff <= '0;
      end else if (cmd.tick_step) begin
         cursor_ff <= cursor_ff + 1'b1;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.reply) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.reply) begin
         rsp_levels_ff <= levels_vec;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_led_levels    = rsp_levels_ff;
   assign stat.func         = func_ff;
   assign stat.last_channel = (cursor_ff == LAST_IDX);
   assign stat.rsp_free     = !rsp_valid_ff || rsp_ready;

endmodule

FILE: rtl/core/multi_channel_led_blinker_top.sv
// channel   direction  payload
// req_chan  in         func, led_index, blink_count, forever_req, period_ms, now_ms
// rsp_chan  out        led_levels
// csr_*     in         led_count (index 0), on_levels (index 1), write only
//
// a tick item takes the channels one per cycle through a single update unit,
// and set, clear and other items take a single edit step; the next item is
// accepted only once the current one has gone to the result register
// reset is synchronous; channels below the reset led count come up in hold
// the result sits in an output register, so a stalled rsp_chan holds one
// result while the next item is accepted and worked on
module multi_channel_led_blinker_top import mclb_pkg::*; #(
   parameter int NUM_LEDS    = 10,
   parameter int COUNT_WIDTH = 8,
   parameter int TIME_WIDTH  = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   mclb_req_if.sink               req_chan,
   mclb_rsp_if.source             rsp_chan,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cmd_type  cmd;
   stat_type stat;

   // sequencer
   mclb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // channel state and update unit
   mclb_dp #(
      .NUM_LEDS    (NUM_LEDS),
      .COUNT_WIDTH (COUNT_WIDTH),
      .TIME_WIDTH  (TIME_WIDTH)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .item_func        (req_chan.func),
      .item_led_index   (req_chan.led_index),
      .item_blink_count (req_chan.blink_count),
      .item_forever_req (req_chan.forever_req),
      .item_period_ms   (req_chan.period_ms),
      .item_now_ms      (req_chan.now_ms),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .rsp_ready        (rsp_chan.ready),
      .rsp_valid        (rsp_chan.valid),
      .rsp_led_levels   (rsp_chan.led_levels)
   );

endmodule

FILE: test/multi_channel_led_blinker_top_test.sv
module multi_channel_led_blinker_top_test;
   import mclb_pkg::*;

   localparam int NUM_CH = 10;
   localparam int PHASE_ITEMS = 258;
   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

   typedef struct {
      logic [FUNC_W-1:0]      func;
      logic [LED_INDEX_W-1:0] led_index;
      logic [COUNT_IN_W-1:0]  blink_count;
      logic                   forever_req;
      logic [PERIOD_W-1:0]    period_ms;
      logic [NOW_W-1:0]       now_ms;
   } led_item_type;

   logic clock;
   logic reset;
   logic                   csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   mclb_req_if req_chan ();
   mclb_rsp_if rsp_chan ();

   multi_channel_led_blinker_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // predicted channel state
   mode_type               chan_mode   [NUM_CH];
   logic [COUNT_IN_W-1:0]  chan_passes [NUM_CH];
   logic                   chan_forever[NUM_CH];
   logic [PERIOD_W-1:0]    chan_period [NUM_CH];
   logic [NOW_W-1:0]       chan_last_ms[NUM_CH];
   logic [LEVELS_W-1:0]    chan_pins;
   logic [LEVELS_W-1:0]    cfg_on_levels;

   led_item_type        pending_items[$];
   logic [LEVELS_W-1:0] levels_expected[$];
   led_item_type        shown_item;
   logic [NOW_W-1:0]    sim_now_ms;
   int                  burst_left;
   int                  gap_left;
   logic [15:0]         stall_pattern;
   int                  pattern_age;
   logic [LEVELS_W-1:0] want_levels;
   int                  mismatches;

   always #10 clock = ~clock;

   // channels below n go back to hold with the initial period
   function automatic void restart_channels(logic [3:0] n);
      for (int i = 0; i < NUM_CH; i++) begin
         if (i < n) begin
            chan_mode[i]    = MODE_HOLD;
            chan_passes[i]  = '0;
            chan_forever[i] = 1'b1;
            chan_period[i]  = INIT_PERIOD;
            chan_last_ms[i] = '0;
         end
      end
   endfunction

   function automatic void apply_csr(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      if (idx == CSR_LED_COUNT) begin
         restart_channels(data[3:0]);
      end else begin
         cfg_on_levels = data[LEVELS_W-1:0];
      end
   endfunction

   // apply one accepted item and queue the levels it reports
   function automatic void predict_levels(led_item_type it);
      logic [NOW_W-1:0] elapsed;
      logic             active;
      if (it.func == FUNC_TICK) begin
         for (int i = 0; i < NUM_CH; i++) begin
            if (chan_mode[i] == MODE_HOLD) begin
               chan_pins[i] = cfg_on_levels[i];
            end else if (chan_mode[i] == MODE_TOGGLE) begin
               active = 1'b1;
               if (!chan_forever[i]) begin
                  if (chan_passes[i] != 0) begin
                     chan_passes[i] = chan_passes[i] - 1'b1;
                  end else begin
                     chan_mode[i] = MODE_HOLD;
                     active = 1'b0;
                  end
               end
               elapsed = it.now_ms - chan_last_ms[i];
               if (active && elapsed >= chan_period[i]) begin
                  chan_pins[i] = ~chan_pins[i];
                  chan_last_ms[i] = it.now_ms;
               end
            end
         end
      end else if (it.func == FUNC_SET && it.led_index < NUM_CH) begin
         chan_passes[it.led_index]  = it.blink_count;
         chan_forever[it.led_index] = it.forever_req;
         chan_period[it.led_index]  = it.period_ms;
         if (it.period_ms == 0 || (!it.forever_req && it.blink_count == 0))
            chan_mode[it.led_index] = MODE_HOLD;
         else
            chan_mode[it.led_index] = MODE_TOGGLE;
      end else if (it.func == FUNC_CLEAR && it.led_index < NUM_CH) begin
         chan_passes[it.led_index]  = '0;
         chan_forever[it.led_index] = 1'b1;
         chan_period[it.led_index]  = '0;
         chan_mode[it.led_index]    = MODE_HOLD;
      end
      levels_expected.push_back(chan_pins);
   endfunction

   function automatic void queue_item(logic [FUNC_W-1:0] func, logic [LED_INDEX_W-1:0] idx,
                                      logic [COUNT_IN_W-1:0] cnt, logic forever_req,
                                      logic [PERIOD_W-1:0] period, logic [NOW_W-1:0] now);
      led_item_type it;
      it.func        = func;
      it.led_index   = idx;
      it.blink_count = cnt;
      it.forever_req = forever_req;
      it.period_ms   = period;
      it.now_ms      = now;
      pending_items.push_back(it);
   endfunction

   // mostly ticks on a running clock and sets with short periods, so channels blink
   function automatic led_item_type random_item();
      led_item_type it;
      int unsigned  pick;
      pick = $urandom_range(0, 99);
      it.led_index   = ($urandom_range(0, 15) == 0) ? 4'($urandom_range(10, 15))
                                                     : 4'($urandom_range(0, 9));
      it.blink_count = ($urandom_range(0, 3) == 0) ? 8'($urandom()) : 8'($urandom_range(0, 12));
      it.forever_req = ($urandom_range(0, 2) == 0);
      case ($urandom_range(0, 7))
         0: it.period_ms = '0;
         1: it.period_ms = 16'($urandom());
         2: it.period_ms = 16'hFFFF;
         default: it.period_ms = 16'($urandom_range(1, 400));
      endcase
      it.now_ms = $urandom();
      if (pick < 50) begin
         it.func = FUNC_TICK;
         if ($urandom_range(0, 19) == 0)
            sim_now_ms = $urandom_range(0, 1) ? $urandom()
                                              : 32'hFFFF_FF00 + $urandom_range(0, 255);
         else
            sim_now_ms = sim_now_ms + $urandom_range(0, 250);
         it.now_ms = sim_now_ms;
      end else if (pick < 82) begin
         it.func = FUNC_SET;
      end else if (pick < 94) begin
         it.func = FUNC_CLEAR;
      end else begin
         it.func = FUNC_UNUSED;
      end
      return it;
   endfunction

   task automatic write_csr(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      apply_csr(idx, data);
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic wait_all_done();
      do
         @(negedge clock);
      while (pending_items.size() != 0 || req_chan.valid || levels_expected.size() != 0);
   endtask

   // item driver: bursts with random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready)
            predict_levels(shown_item);
         if (!req_chan.valid || req_chan.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_chan.valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
               shown_item = pending_items.pop_front();
               req_chan.valid       <= 1'b1;
               req_chan.func        <= shown_item.func;
               req_chan.led_index   <= shown_item.led_index;
               req_chan.blink_count <= shown_item.blink_count;
               req_chan.forever_req <= shown_item.forever_req;
               req_chan.period_ms   <= shown_item.period_ms;
               req_chan.now_ms      <= shown_item.now_ms;
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 40);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
               end
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // result monitor with a rotating stall pattern
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         stall_pattern = '1;
         pattern_age = 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (levels_expected.size() == 0) begin
               $display("%0t: unexpected result, expected none, got led_levels %h",
                        $time, rsp_chan.led_levels);
               mismatches++;
            end else begin
               want_levels = levels_expected.pop_front();
               if (rsp_chan.led_levels !== want_levels) begin
                  $display("%0t: led_levels mismatch, expected %h, got %h",
                           $time, want_levels, rsp_chan.led_levels);
                  mismatches++;
               end
            end
         end
         stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
         pattern_age++;
         if (pattern_age == 300) begin
            pattern_age = 0;
            stall_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                                        : 16'($urandom_range(1, 16'hFFFF));
         end
         rsp_chan.ready <= stall_pattern[0];
      end
   end

   initial begin
      #10_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      logic [3:0]          count_list[6];
      logic [LEVELS_W-1:0] level_list[6];
      clock = 1'b0;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_chan.valid       = 1'b0;
      req_chan.func        = '0;
      req_chan.led_index   = '0;
      req_chan.blink_count = '0;
      req_chan.forever_req = 1'b0;
      req_chan.period_ms   = '0;
      req_chan.now_ms      = '0;
      rsp_chan.ready = 1'b0;
      mismatches = 0;
      burst_left = 0;
      gap_left = 0;
      sim_now_ms = '0;

      // state after reset
      cfg_on_levels = ON_LEVELS_RESET;
      chan_pins = '0;
      for (int i = 0; i < NUM_CH; i++) begin
         chan_mode[i]    = MODE_IDLE;
         chan_passes[i]  = '0;
         chan_forever[i] = 1'b1;
         chan_period[i]  = INIT_PERIOD;
         chan_last_ms[i] = '0;
      end
      restart_channels(LED_COUNT_RESET);

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // counted blink that runs out, then falls back to hold
      queue_item(FUNC_TICK, 4'd0, 8'd0, 1'b0, 16'd0, 32'd0);
      queue_item(FUNC_SET, 4'd0, 8'd2, 1'b0, 16'd1, 32'd0);
      queue_item(FUNC_TICK, 4'd0, 8'd0, 1'b0, 16'd0, 32'd1);
      queue_item(FUNC_TICK, 4'd0, 8'd0, 1'b0, 16'd0, 32'd1);
      queue_item(FUNC_TICK, 4'd0, 8'd0, 1'b0, 16'd0, 32'd5);
      queue_item(FUNC_TICK, 4'd0, 8'd0, 1'b0, 16'd0, 32'd6);
      // longest period across the time wrap
      queue_item(FUNC_SET, 4'd1, 8'hFF, 1'b1, 16'hFFFF, 32'd0);
      queue_item(FUNC_TICK, 4'd0, 8'd0, 1'b0, 16'd0, 32'hFFFF_FFFF);
      queue_item(FUNC_TICK, 4'd0, 8'd0, 1'b0, 16'd0, 32'h0000_FFFE);
      // sets that mean hold: zero count without forever, zero period; then blinking sets, a tick, a clear
      queue_item(FUNC_SET, 4'd2, 8'd0, 1'b0, 16'd100, 32'd0);
      queue_item(FUNC_SET, 4'd3, 8'd5, 1'b1, 16'd0, 32'd0);
      queue_item(FUNC_SET, 4'd4, 8'd0, 1'b1, 16'd1, 32'd0);
      queue_item(FUNC_SET, 4'd9, 8'hFF, 1'b0, 16'h8000, 32'd0);
      queue_item(FUNC_TICK, 4'd0, 8'd0, 1'b0, 16'd0, 32'h8000_0000);
      queue_item(FUNC_CLEAR, 4'd1, 8'd0, 1'b0, 16'd0, 32'd0);
      // out of range channels are ignored
      queue_item(FUNC_SET, 4'd10, 8'd3, 1'b1, 16'd1, 32'd0);
      queue_item(FUNC_SET, 4'd15, 8'hFF, 1'b1, 16'hFFFF, 32'hFFFF_FFFF);
      queue_item(FUNC_CLEAR, 4'd12, 8'd0, 1'b0, 16'd0, 32'd0);
      // unused func only reports levels
      queue_item(FUNC_UNUSED, 4'hF, 8'hFF, 1'b1, 16'hFFFF, 32'hFFFF_FFFF);
      queue_item(FUNC_TICK, 4'd0, 8'd0, 1'b0, 16'd0, 32'h8000_7FFF);
      queue_item(FUNC_CLEAR, 4'd4, 8'd0, 1'b0, 16'd0, 32'd0);
      queue_item(FUNC_TICK, 4'd0, 8'd0, 1'b0, 16'd0, 32'h8001_0000);

      // register settings per phase, extremes included; 15 saturates the count
      count_list = '{4'd0, 4'd15, 4'd5, 4'd1, 4'd10, 4'($urandom_range(0, 10))};
      level_list = '{10'h000, 10'h2AA, 10'h155, 10'h3FF, 10'h000, 10'($urandom())};

      for (int p = 0; p < 6; p++) begin
         wait_all_done();
         write_csr(CSR_LED_COUNT, CSR_DATA_W'(count_list[p]));
         write_csr(CSR_ON_LEVELS, level_list[p]);
         for (int n = 0; n < PHASE_ITEMS; n++)
            pending_items.push_back(random_item());
      end

      wait_all_done();
      repeat (40) @(posedge clock);
      if (mismatches == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

FILE: multi_channel_led_blinker_top.f
rtl/core/mclb_pkg.sv
rtl/core/mclb_req_if.sv
rtl/core/mclb_rsp_if.sv
rtl/core/mclb_ctrl.sv
rtl/core/mclb_dp.sv
rtl/core/multi_channel_led_blinker_top.sv
test/multi_channel_led_blinker_top_test.sv
